/* rtl/lfba_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Lowest-free block allocator package
// Types, constants and priority encoders shared by the allocator modules.
// ---------------------------------------------------------------------------
package lfba_pkg;

   localparam int BLOCK_COUNT = 1024;
   localparam int WORD_W      = 16;
   localparam int BIT_W       = $clog2(WORD_W);
   localparam int ROWS        = BLOCK_COUNT / WORD_W;
   localparam int ROW_W       = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int IDX_W       = $clog2(BLOCK_COUNT);

   typedef enum logic [1:0] {
      KIND_ALLOC     = 2'd0,
      KIND_FREE      = 2'd1,
      KIND_FREE_TEMP = 2'd2,
      KIND_SYNC      = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK           = 2'd0,
      ST_ALREADY_FREE = 2'd1,
      ST_NOT_TEMP     = 2'd2,
      ST_EXHAUSTED    = 2'd3
   } status_type;

   typedef enum logic {
      S_IDLE,
      S_MODIFY
   } state_type;

   typedef struct packed {
      kind_type    kind;
      logic [9:0]  block;
   } req_type;

   typedef struct packed {
      logic [9:0]  given_block;
      logic        reused;
      status_type  status;
   } rsp_type;

   typedef struct packed {
      logic [WORD_W-1:0] temp_bits;
      logic [WORD_W-1:0] free_bits;
   } word_type;

   typedef struct packed {
      logic             we;
      logic [ROW_W-1:0] addr;
      word_type         wdata;
   } ram_req_type;

   function automatic logic [ROW_W-1:0] lowest_row(input logic [ROWS-1:0] v);
      logic [ROW_W-1:0] r;
      r = '0;
      for (int i = ROWS - 1; i >= 0; i--) begin
         if (v[i]) begin
            r = ROW_W'(i);
         end
      end
      return r;
   endfunction

   function automatic logic [BIT_W-1:0] lowest_bit(input logic [WORD_W-1:0] v);
      logic [BIT_W-1:0] r;
      r = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (v[i]) begin
            r = BIT_W'(i);
         end
      end
      return r;
   endfunction

endpackage

/* rtl/lfba_map_ram.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Allocator bitmap RAM
// One row per word: free bits and temporary bits side by side.
// Single port, registered read data.
// ---------------------------------------------------------------------------
module lfba_map_ram (
   input  logic                  clock,
   input  lfba_pkg::ram_req_type ram_req,
   output lfba_pkg::word_type    rdata
);

   lfba_pkg::word_type mem [lfba_pkg::ROWS];

   always_ff @(posedge clock) begin
      if (ram_req.we) begin
         mem[ram_req.addr] <= ram_req.wdata;
      end
      rdata <= mem[ram_req.addr];
   end

endmodule

/* rtl/lfba_ctrl.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Allocator control
// Row selection, read-modify-write of the bitmap RAM, summary and row-valid
// bits, high-water counter and response generation.
// ---------------------------------------------------------------------------
module lfba_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  lfba_pkg::req_type     req_item,
   output logic                  rsp_strobe,
   output lfba_pkg::rsp_type     rsp_item,
   output lfba_pkg::ram_req_type ram_req,
   input  lfba_pkg::word_type    ram_rdata
);

   lfba_pkg::state_type           state_ff, state_in;
   lfba_pkg::kind_type            kind_ff, kind_in;
   logic [lfba_pkg::IDX_W-1:0]    idx_ff, idx_in;
   logic [lfba_pkg::ROW_W-1:0]    row_ff, row_in;
   logic                          exh_ff, exh_in;
   logic                          ctr_ff, ctr_in;
   logic                          oor_ff, oor_in;
   logic [lfba_pkg::ROWS-1:0]     valid_ff, valid_in;
   logic [lfba_pkg::ROWS-1:0]     summ_ff, summ_in;
   logic [lfba_pkg::IDX_W-1:0]    hw_ff, hw_in;

   logic [lfba_pkg::IDX_W-1:0]    hw_next;
   lfba_pkg::word_type            cur_word;
   lfba_pkg::word_type            new_word;
   logic [lfba_pkg::BIT_W-1:0]    bit_sel;
   logic [lfba_pkg::BIT_W-1:0]    low_bit;

   assign hw_next = hw_ff + lfba_pkg::IDX_W'(1);
   assign cur_word = valid_ff[row_ff] ? ram_rdata : '0;
   assign low_bit  = lfba_pkg::lowest_bit(cur_word.free_bits);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lfba_pkg::S_IDLE;
         valid_ff <= '0;
         summ_ff  <= '0;
         hw_ff    <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         summ_ff  <= summ_in;
         hw_ff    <= hw_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      idx_ff  <= idx_in;
      row_ff  <= row_in;
      exh_ff  <= exh_in;
      ctr_ff  <= ctr_in;
      oor_ff  <= oor_in;
   end

   always_comb begin
      state_in   = state_ff;
      kind_in    = kind_ff;
      idx_in     = idx_ff;
      row_in     = row_ff;
      exh_in     = exh_ff;
      ctr_in     = ctr_ff;
      oor_in     = oor_ff;
      valid_in   = valid_ff;
      summ_in    = summ_ff;
      hw_in      = hw_ff;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      rsp_item   = '0;
      new_word   = cur_word;
      bit_sel    = idx_ff[lfba_pkg::BIT_W-1:0];
      ram_req.we    = 1'b0;
      ram_req.addr  = row_ff;
      ram_req.wdata = new_word;

      case (state_ff)
         lfba_pkg::S_IDLE: begin
            busy    = 1'b0;
            kind_in = req_item.kind;
            exh_in  = 1'b0;
            ctr_in  = 1'b0;
            oor_in  = 1'b0;
            if (req_item.kind == lfba_pkg::KIND_ALLOC) begin
               idx_in = hw_next;
               if (summ_ff != '0) begin
                  row_in = lfba_pkg::lowest_row(summ_ff);
               end else if (hw_ff >= lfba_pkg::IDX_W'(lfba_pkg::BLOCK_COUNT - 1)) begin
                  exh_in = 1'b1;
                  row_in = row_ff;
               end else begin
                  ctr_in = 1'b1;
                  row_in = lfba_pkg::ROW_W'(hw_next >> lfba_pkg::BIT_W);
               end
            end else begin
               idx_in = lfba_pkg::IDX_W'(req_item.block);
               oor_in = !(32'(req_item.block) < 32'(lfba_pkg::BLOCK_COUNT));
               row_in = lfba_pkg::ROW_W'(lfba_pkg::IDX_W'(req_item.block) >> lfba_pkg::BIT_W);
            end
            ram_req.addr = row_in;
            if (start) begin
               state_in = lfba_pkg::S_MODIFY;
            end
         end
         lfba_pkg::S_MODIFY: begin
            rsp_strobe = 1'b1;
            state_in   = lfba_pkg::S_IDLE;
            case (kind_ff)
               lfba_pkg::KIND_ALLOC: begin
                  if (exh_ff) begin
                     rsp_item.status = lfba_pkg::ST_EXHAUSTED;
                  end else if (ctr_ff) begin
                     new_word.temp_bits[bit_sel] = 1'b1;
                     ram_req.we = 1'b1;
                     hw_in = idx_ff;
                     rsp_item.given_block = 10'(idx_ff);
                  end else begin
                     new_word.free_bits[low_bit] = 1'b0;
                     new_word.temp_bits[low_bit] = 1'b1;
                     ram_req.we = 1'b1;
                     summ_in[row_ff] = |new_word.free_bits;
                     rsp_item.given_block = 10'({row_ff, low_bit});
                     rsp_item.reused = 1'b1;
                  end
               end
               lfba_pkg::KIND_FREE: begin
                  if (!oor_ff) begin
                     if (cur_word.free_bits[bit_sel]) begin
                        rsp_item.status = lfba_pkg::ST_ALREADY_FREE;
                     end else begin
                        new_word.free_bits[bit_sel] = 1'b1;
                        ram_req.we = 1'b1;
                        summ_in[row_ff] = 1'b1;
                     end
                  end
               end
               default: begin
                  // free-temp and sync
                  if (!oor_ff) begin
                     if (cur_word.temp_bits[bit_sel]) begin
                        new_word.temp_bits[bit_sel] = 1'b0;
                        ram_req.we = 1'b1;
                     end else begin
                        rsp_item.status = lfba_pkg::ST_NOT_TEMP;
                     end
                  end
               end
            endcase
            ram_req.wdata = new_word;
            if (ram_req.we) begin
               valid_in[row_ff] = 1'b1;
            end
         end
         default: begin
            state_in = lfba_pkg::S_IDLE;
         end
      endcase
   end

   a_write_only_in_modify: assert property (@(posedge clock) disable iff (reset)
      ram_req.we |-> (state_ff == lfba_pkg::S_MODIFY))
      else $error("bitmap write outside modify state");

   a_accept_gives_response: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_strobe)
      else $error("accepted request without response");

   a_exhausted_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.status == lfba_pkg::ST_EXHAUSTED) |->
         (rsp_item.given_block == '0 && !rsp_item.reused && summ_ff == '0))
      else $error("exhausted response with a block or free rows");

   a_reuse_needs_summary: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.reused) |-> summ_ff[row_ff])
      else $error("reused block from a row with no free bits");

   a_hw_in_range: assert property (@(posedge clock) disable iff (reset)
      hw_ff <= lfba_pkg::IDX_W'(lfba_pkg::BLOCK_COUNT - 1))
      else $error("high-water counter past capacity");

endmodule

/* rtl/lowest_free_block_allocator_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Lowest-free block allocator
// Hands out block numbers lowest-free first, falling back to a high-water
// counter; tracks freed and temporary blocks in a bitmap RAM.
// ---------------------------------------------------------------------------
// For each request, the accept cycle issues the bitmap RAM read
// (row picked from a per-row free summary or from the counter), the next
// cycle modifies and writes back the row and drives rsp_strobe for exactly
// one cycle. busy is high during that modify cycle, so no new request can
// be started until the response is given. The receiver cannot stall the
// response. No clearing pass after reset: per-row valid bits make unwritten
// rows read as empty, so requests are taken right after reset.
module lowest_free_block_allocator_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  lfba_pkg::req_type req_item,
   output logic              rsp_strobe,
   output lfba_pkg::rsp_type rsp_item
);

   lfba_pkg::ram_req_type ram_req;
   lfba_pkg::word_type    ram_rdata;

   lfba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .ram_req    (ram_req),
      .ram_rdata  (ram_rdata)
   );

   lfba_map_ram u_map_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rdata   (ram_rdata)
   );

endmodule
